// File: hw/rtl/tftu_pkg.sv
// Package with shared widths, constants, codes and types of the TLB page translation unit.
package tftu_pkg;

   localparam int ACTION_W = 2;
   localparam int PAGE_W   = 4;
   localparam int FRAME_W  = 4;
   localparam int OFFSET_W = 4;
   localparam int DATA_W   = 32;

   // The page, frame and offset fields are four bits wide, so every table spans the full code.
   localparam int PAGES           = 1 << PAGE_W;
   localparam int FRAMES          = 1 << FRAME_W;
   localparam int WORDS_PER_FRAME = 1 << OFFSET_W;
   localparam int STORE_WORDS     = FRAMES * WORDS_PER_FRAME;
   localparam int ADDR_W          = FRAME_W + OFFSET_W;

   localparam int TLB_ENTRIES_DEFAULT = 8;

   localparam logic [DATA_W-1:0] STORE_RESET_WORD = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TRANSLATE = 2'd0,
      ACT_LOAD_MAP  = 2'd1,
      ACT_LOAD_DATA = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
   } entry_type;

   typedef struct packed {
      logic              shift;
      logic [PAGE_W-1:0] key;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/tftu_req_if.sv
// Request channel interface: valid/ready handshake with the translate or load request fields.
interface tftu_req_if;
   import tftu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ACTION_W-1:0]      action;
   logic [PAGE_W-1:0]        page;
   logic [OFFSET_W-1:0]      offset;
   logic [FRAME_W-1:0]       frame_in;
   logic signed [DATA_W-1:0] data_in;

   modport source (output valid, action, page, offset, frame_in, data_in, input ready);
   modport sink   (input valid, action, page, offset, frame_in, data_in, output ready);
endinterface

// File: hw/rtl/tftu_rsp_if.sv
// Response channel interface: valid/ready handshake with the hit flag, frame and data word.
interface tftu_rsp_if;
   import tftu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic [FRAME_W-1:0]       frame_out;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, hit, frame_out, value, input ready);
   modport sink   (input valid, hit, frame_out, value, output ready);
endinterface

// File: hw/rtl/tftu_tlb_cell.sv
// One TLB cell: holds a page/frame pair, compares it with the search key and shifts on a fill.
module tftu_tlb_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tftu_pkg::cell_ctrl_type ctrl,
   input  tftu_pkg::entry_type    prev,
   output tftu_pkg::entry_type    entry,
   output logic                   match
);
   import tftu_pkg::*;

   logic               valid_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [FRAME_W-1:0] frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         page_ff  <= prev.page;
         frame_ff <= prev.frame;
      end
   end

   assign entry.valid = valid_ff;
   assign entry.page  = page_ff;
   assign entry.frame = frame_ff;
   assign match       = valid_ff && (page_ff == ctrl.key);
endmodule

// File: hw/rtl/tftu_data_store.sv
// Single-port data word memory with a registered read port.
module tftu_data_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic                        rd_en,
   input  logic [tftu_pkg::ADDR_W-1:0] addr,
   input  logic [tftu_pkg::DATA_W-1:0] wr_data,
   output logic [tftu_pkg::DATA_W-1:0] rd_data
);
   import tftu_pkg::*;

   logic [DATA_W-1:0] mem_ff [STORE_WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/tlb_fifo_page_translate_unit.sv
// Top level of the TLB page translation unit with FIFO replacement.
// A request is taken only in the idle state, so the next one waits until the previous
// result has been loaded into the output register, which happens once it is empty or drained.
// The TLB is a chain of cells; a miss shifts the new pair into the first cell.
// Reset empties the TLB, restores the identity page map and then fills all 256 words of
// the data memory with all ones, during which no request is taken.
module tlb_fifo_page_translate_unit #(
   parameter int TLB_ENTRIES = tftu_pkg::TLB_ENTRIES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tftu_req_if.sink   req_chan,
   tftu_rsp_if.source rsp_chan
);
   import tftu_pkg::*;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0]  clear_addr_ff, clear_addr_in;
   logic [FRAME_W-1:0] page_map_ff [PAGES];

   logic req_ready, accept, clear_we, load_rsp;
   action_type req_act;
   logic do_translate, do_load_map, do_load_data, fill;

   entry_type     cell_entry [TLB_ENTRIES];
   entry_type     new_entry;
   cell_ctrl_type cell_ctrl;
   logic [TLB_ENTRIES-1:0] match_vec;
   logic               tlb_hit;
   logic [FRAME_W-1:0] tlb_frame, map_frame, lookup_frame;

   logic              store_we, store_re;
   logic [ADDR_W-1:0] store_addr;
   logic [DATA_W-1:0] store_wdata, store_rdata;

   logic               hit_ff, translate_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic [DATA_W-1:0]  rsp_value_ff;

   // Control sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      req_ready     = 1'b0;
      clear_we      = 1'b0;
      load_rsp      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_we      = 1'b1;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == ADDR_W'(STORE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // The output register takes the result once it is empty or being drained.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;
   assign req_act        = action_type'(req_chan.action);
   assign do_translate   = accept && (req_act == ACT_TRANSLATE);
   assign do_load_map    = accept && (req_act == ACT_LOAD_MAP);
   assign do_load_data   = accept && (req_act == ACT_LOAD_DATA);

   // Page table.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAGES; i++) begin
            page_map_ff[i] <= FRAME_W'(i);
         end
      end else if (do_load_map) begin
         page_map_ff[req_chan.page] <= req_chan.frame_in;
      end
   end

   assign map_frame = page_map_ff[req_chan.page];

   // TLB cell chain. A fill pushes the newest pair into cell 0 and drops the oldest one,
   // which is the same eviction order as a wrapping replacement pointer.
   assign fill            = do_translate && !tlb_hit;
   assign cell_ctrl.shift = fill;
   assign cell_ctrl.key   = req_chan.page;
   assign new_entry.valid = 1'b1;
   assign new_entry.page  = req_chan.page;
   assign new_entry.frame = map_frame;

   for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
      entry_type prev_entry;
      if (g == 0) begin : g_head
         assign prev_entry = new_entry;
      end else begin : g_body
         assign prev_entry = cell_entry[g-1];
      end
      tftu_tlb_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (cell_ctrl),
         .prev  (prev_entry),
         .entry (cell_entry[g]),
         .match (match_vec[g])
      );
   end

   always_comb begin
      tlb_frame = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         tlb_frame = tlb_frame | (cell_entry[i].frame & {FRAME_W{match_vec[i]}});
      end
   end

   assign tlb_hit      = |match_vec;
   assign lookup_frame = tlb_hit ? tlb_frame : map_frame;

   // Data memory port.
   always_comb begin
      priority if (clear_we) begin
         store_addr  = clear_addr_ff;
         store_wdata = STORE_RESET_WORD;
      end else if (do_load_data) begin
         store_addr  = {req_chan.frame_in, req_chan.offset};
         store_wdata = req_chan.data_in;
      end else begin
         store_addr  = {lookup_frame, req_chan.offset};
         store_wdata = req_chan.data_in;
      end
   end

   assign store_we = clear_we || do_load_data;
   assign store_re = do_translate;

   tftu_data_store u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .rd_en   (store_re),
      .addr    (store_addr),
      .wr_data (store_wdata),
      .rd_data (store_rdata)
   );

   // Lookup results held until the data word returns.
   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff       <= tlb_hit;
         frame_ff     <= lookup_frame;
         translate_ff <= (req_act == ACT_TRANSLATE);
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_hit_ff   <= translate_ff && hit_ff;
         rsp_frame_ff <= translate_ff ? frame_ff : '0;
         rsp_value_ff <= translate_ff ? store_rdata : '0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.hit       = rsp_hit_ff;
   assign rsp_chan.frame_out = rsp_frame_ff;
   assign rsp_chan.value     = rsp_value_ff;

   // A page is cached at most once, since cells are filled only on a miss.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one TLB cell matches the key");

   // A fill leaves the new pair in the head cell.
   a_fill_head: assert property (@(posedge clock) disable iff (reset)
      fill |=> (cell_entry[0].valid && cell_entry[0].page == $past(req_chan.page)
                && cell_entry[0].frame == $past(map_frame)))
      else $error("filled pair missing from the head cell");

   // Every request transfer is followed by the response cycle.
   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RESP))
      else $error("request transfer not followed by the response cycle");

   // A new response appears only out of the response cycle.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_chan.ready)) |-> (state_ff == ST_RESP))
      else $error("response loaded outside the response cycle");
endmodule

// File: tb/sv/tlb_fifo_page_translate_unit_checker.sv
// Checker that predicts the response to every request of the TLB unit and compares the responses against it.
module tlb_translate_checker #(
   parameter int TLB_ENTRIES = tftu_pkg::TLB_ENTRIES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   tftu_req_if  req_mon,
   tftu_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tftu_pkg::*;

   typedef struct packed {
      logic                     hit;
      logic [FRAME_W-1:0]       frame;
      logic signed [DATA_W-1:0] value;
   } translation_type;

   entry_type                tlb [TLB_ENTRIES];
   int unsigned              fill_slot;
   logic [FRAME_W-1:0]       page_map [PAGES];
   logic signed [DATA_W-1:0] word_store [STORE_WORDS];
   translation_type          expected_translations [$];
   translation_type          want;
   int                       errors = 0;

   // Applies one request to the shadow state and returns the response it should produce.
   function automatic translation_type predict_access(
      input logic [ACTION_W-1:0]      act,
      input logic [PAGE_W-1:0]        page,
      input logic [OFFSET_W-1:0]      offset,
      input logic [FRAME_W-1:0]       frame_in,
      input logic signed [DATA_W-1:0] data_in
   );
      translation_type res;
      logic            found;
      res   = '0;
      found = 1'b0;
      case (act)
         ACT_TRANSLATE: begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
               if (!found && tlb[i].valid && tlb[i].page == page) begin
                  res.frame = tlb[i].frame;
                  found     = 1'b1;
               end
            end
            if (found) begin
               res.hit = 1'b1;
            end else begin
               // A miss replaces the oldest entry, which is what the shift chain drops.
               res.frame       = page_map[page];
               tlb[fill_slot]  = '{valid: 1'b1, page: page, frame: res.frame};
               fill_slot       = (fill_slot + 1) % TLB_ENTRIES;
            end
            res.value = word_store[{res.frame, offset}];
         end
         ACT_LOAD_MAP: begin
            page_map[page] = frame_in;
         end
         ACT_LOAD_DATA: begin
            word_store[{frame_in, offset}] = data_in;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TLB_ENTRIES; i++) tlb[i] = '0;
         for (int i = 0; i < PAGES; i++) page_map[i] = FRAME_W'(i);
         for (int i = 0; i < STORE_WORDS; i++) word_store[i] = STORE_RESET_WORD;
         fill_slot = 0;
         expected_translations.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_translations.size() == 0) begin
               $display("%0t: response with nothing expected: hit %0b frame %0d value %0d",
                        $time, rsp_mon.hit, rsp_mon.frame_out, rsp_mon.value);
               errors++;
            end else begin
               want = expected_translations.pop_front();
               if (rsp_mon.hit !== want.hit) begin
                  $display("%0t: hit mismatch, expected %0b, actual %0b",
                           $time, want.hit, rsp_mon.hit);
                  errors++;
               end
               if (rsp_mon.frame_out !== want.frame) begin
                  $display("%0t: frame mismatch, expected %0d, actual %0d",
                           $time, want.frame, rsp_mon.frame_out);
                  errors++;
               end
               if (rsp_mon.value !== want.value) begin
                  $display("%0t: value mismatch, expected %0d, actual %0d",
                           $time, want.value, rsp_mon.value);
                  errors++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_translations.push_back(predict_access(req_mon.action, req_mon.page,
               req_mon.offset, req_mon.frame_in, req_mon.data_in));
         end
      end
      fail_count <= errors;
      pending    <= expected_translations.size();
   end

endmodule

// File: tb/sv/tlb_fifo_page_translate_unit_tb.sv
// Testbench top for the TLB page translation unit: stimulus, response stalls, watchdog and verdict.
module tlb_fifo_page_translate_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tftu_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS    = 2000;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int HOLD_OFF_AFTER  = 300;
   localparam int HOLD_OFF_CYCLES = 400;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   sent_count      = 0;
   int   idle_cycles     = 0;
   int   quiet_items     = 0;
   bit   hold_off_active = 1'b0;
   bit   hold_off_done   = 1'b0;

   tftu_req_if req_chan ();
   tftu_rsp_if rsp_chan ();

   tlb_fifo_page_translate_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   tlb_translate_checker translation_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int next_gap();
      int pick;
      if (hold_off_active) return 0;
      if (quiet_items > 0) begin
         quiet_items--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
         quiet_items = $urandom_range(30, 100);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(
      input logic [ACTION_W-1:0]      act,
      input logic [PAGE_W-1:0]        page,
      input logic [OFFSET_W-1:0]      offset,
      input logic [FRAME_W-1:0]       frame_in,
      input logic signed [DATA_W-1:0] data_in
   );
      int gap;
      req_chan.valid    <= 1'b1;
      req_chan.action   <= act;
      req_chan.page     <= page;
      req_chan.offset   <= offset;
      req_chan.frame_in <= frame_in;
      req_chan.data_in  <= data_in;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
      gap = next_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: random stalls, calm stretches, and one long hold-off that backs up the unit.
   initial begin
      int stall_left;
      int calm_left;
      int pick;
      stall_left = 0;
      calm_left  = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_off_done && sent_count >= HOLD_OFF_AFTER) begin
            hold_off_active = 1'b1;
            rsp_chan.ready <= 1'b0;
            for (int held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clock);
            hold_off_active = 1'b0;
            hold_off_done   = 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               calm_left = $urandom_range(50, 150);
            end else if (pick < 6) begin
               stall_left = $urandom_range(10, 40);
            end else if (pick < 30) begin
               stall_left = $urandom_range(1, 3);
            end
            rsp_chan.ready <= (stall_left == 0);
         end
      end
   end

   initial begin
      int                       ws_base;
      int                       ws_span;
      int                       pick;
      logic [PAGE_W-1:0]        page;
      logic signed [DATA_W-1:0] word;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.action   <= ACT_TRANSLATE;
      req_chan.page     <= '0;
      req_chan.offset   <= '0;
      req_chan.frame_in <= '0;
      req_chan.data_in  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // A cold miss reads the reset word, and the same page then hits.
      send_item(ACT_TRANSLATE, 4'd0, 4'd0, 4'd0, '0);
      send_item(ACT_TRANSLATE, 4'd0, 4'd15, 4'd15, '1);
      send_item(ACT_LOAD_DATA, 4'd0, 4'd15, 4'd15, 32'h7fff_ffff);
      send_item(ACT_LOAD_DATA, 4'd15, 4'd0, 4'd0, 32'h8000_0000);
      send_item(ACT_LOAD_DATA, 4'd0, 4'd15, 4'd0, 32'h0000_0000);
      send_item(ACT_LOAD_MAP, 4'd15, 4'd0, 4'd0, '0);
      send_item(ACT_TRANSLATE, 4'd15, 4'd0, 4'd0, '0);
      // Remapping a cached page leaves the old frame in the TLB until it is evicted.
      send_item(ACT_LOAD_MAP, 4'd15, 4'd15, 4'd15, '1);
      send_item(ACT_TRANSLATE, 4'd15, 4'd15, 4'd0, '0);
      for (int p = 1; p <= 8; p++) begin
         send_item(ACT_TRANSLATE, PAGE_W'(p), OFFSET_W'(p), 4'd0, '0);
      end
      send_item(ACT_TRANSLATE, 4'd15, 4'd15, 4'd0, '0);
      send_item(ACT_TRANSLATE, 4'd0, 4'd0, 4'd0, '0);
      send_item(ACT_UNUSED, 4'd15, 4'd15, 4'd15, '1);
      send_item(ACT_UNUSED, 4'd0, 4'd0, 4'd0, '0);
      send_item(ACT_LOAD_MAP, 4'd0, 4'd0, 4'd15, '1);

      ws_base = 0;
      ws_span = 16;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Working sets of varying size give runs of hits as well as steady eviction.
         if (n % 64 == 0) begin
            ws_base = $urandom_range(0, 15);
            pick    = $urandom_range(0, 3);
            ws_span = (pick == 0) ? 2 : (pick == 1) ? 6 : (pick == 2) ? 10 : 16;
         end
         page = PAGE_W'(ws_base + $urandom_range(0, ws_span - 1));
         word = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            send_item(ACT_TRANSLATE, page, OFFSET_W'($urandom), FRAME_W'($urandom), word);
         end else if (pick < 74) begin
            send_item(ACT_LOAD_MAP, PAGE_W'($urandom), OFFSET_W'($urandom),
                      FRAME_W'($urandom), word);
         end else if (pick < 95) begin
            send_item(ACT_LOAD_DATA, PAGE_W'($urandom), OFFSET_W'($urandom),
                      FRAME_W'($urandom), word);
         end else begin
            send_item(ACT_UNUSED, page, OFFSET_W'($urandom), FRAME_W'($urandom), word);
         end
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: tlb_fifo_page_translate_unit.f
hw/rtl/tftu_pkg.sv
hw/rtl/tftu_req_if.sv
hw/rtl/tftu_rsp_if.sv
hw/rtl/tftu_tlb_cell.sv
hw/rtl/tftu_data_store.sv
hw/rtl/tlb_fifo_page_translate_unit.sv
tb/sv/tlb_fifo_page_translate_unit_checker.sv
tb/sv/tlb_fifo_page_translate_unit_tb.sv
